[src/gclp_pkg.sv]
// Shared types and constants for the G-code line parser.
// Character codes, result kinds, parse phases and the result word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gclp_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_M       = 8'h4D;
  localparam logic [7:0] CH_X       = 8'h58;
  localparam logic [7:0] CH_Y       = 8'h59;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Result kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  // Argument axis indexes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_F = 2'd3;

  localparam logic [15:0]        OPCODE_MAX = 16'hFFFF;
  localparam logic signed [31:0] ARG_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ARG_MIN    = 32'sh8000_0000;

  // Parse phase within a line
  typedef enum logic [3:0] {
    PH_LETTER   = 4'b0001,
    PH_OPCODE   = 4'b0010,
    PH_ARG_NAME = 4'b0100,
    PH_ARG_DIG  = 4'b1000
  } phase_t;

  typedef logic signed [31:0] arg_t;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic        letter_is_m;
    logic [15:0] opcode;
    logic [3:0]  present_mask;
    arg_t        x_value;
    arg_t        y_value;
    arg_t        z_value;
    arg_t        feed_value;
  } result_t;

endpackage

`default_nettype wire

[src/gclp_if.sv]
// Valid/ready channel interfaces for the G-code line parser.
// gclp_in_if carries received bytes, gclp_out_if carries parse results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gclp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               letter_is_m;
  logic [15:0]        opcode;
  logic [3:0]         present_mask;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] z_value;
  logic signed [31:0] feed_value;

  modport source (output valid, output kind, output letter_is_m, output opcode,
                  output present_mask, output x_value, output y_value,
                  output z_value, output feed_value, input ready);
  modport sink   (input valid, input kind, input letter_is_m, input opcode,
                  input present_mask, input x_value, input y_value,
                  input z_value, input feed_value, output ready);
endinterface

`default_nettype wire

[src/gclp_core.sv]
// Parser state and per-byte update for the G-code line parser.
// Holds program, comment and line state; computes the result of one byte.
// Depends on gclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gclp_core
  import gclp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output result_t         res
);

  logic        in_program_r, in_program_nxt;
  logic        in_comment_r, in_comment_nxt;
  phase_t      phase_r, phase_nxt;
  logic        line_error_r, line_error_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic        letter_r, letter_nxt;
  logic [15:0] opcode_r, opcode_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        neg_r, neg_nxt;
  arg_t        args_r [4];
  arg_t        args_nxt [4];
  logic [3:0]  present_r, present_nxt;

  logic               is_digit;
  logic [3:0]         digit;
  logic [19:0]        op_wide;
  arg_t               arg_cur;
  logic signed [35:0] arg_ext;
  logic signed [35:0] arg_wide;
  logic               do_clear;
  logic               do_finish;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = 4'(rx_byte - CH_ZERO);

  // Opcode times ten plus digit
  assign op_wide = {1'b0, opcode_r, 3'b000} + {3'b000, opcode_r, 1'b0} + {16'd0, digit};

  // Argument times ten plus or minus digit
  assign arg_cur  = args_r[axis_r];
  assign arg_ext  = {{4{arg_cur[31]}}, arg_cur};
  assign arg_wide = neg_r ? ((arg_ext <<< 3) + (arg_ext <<< 1) - $signed({32'd0, digit}))
                          : ((arg_ext <<< 3) + (arg_ext <<< 1) + $signed({32'd0, digit}));

  always_comb begin
    in_program_nxt = in_program_r;
    in_comment_nxt = in_comment_r;
    phase_nxt      = phase_r;
    line_error_nxt = line_error_r;
    nonempty_nxt   = nonempty_r;
    letter_nxt     = letter_r;
    opcode_nxt     = opcode_r;
    axis_nxt       = axis_r;
    neg_nxt        = neg_r;
    present_nxt    = present_r;
    for (int i = 0; i < 4; i++) args_nxt[i] = args_r[i];
    res_valid = 1'b0;
    res       = '0;
    do_clear  = 1'b0;
    do_finish = 1'b0;

    // Program boundary, comments and line end
    if (!in_program_r) begin
      if (rx_byte == CH_PERCENT) begin
        in_program_nxt = 1'b1;
        in_comment_nxt = 1'b1;
        do_clear       = 1'b1;
        res_valid      = 1'b1;
        res.kind       = KIND_START;
      end
    end else if (in_comment_r) begin
      if (rx_byte == CH_LF) begin
        in_comment_nxt = 1'b0;
        do_finish      = 1'b1;
      end
    end else if (rx_byte == CH_PERCENT) begin
      in_program_nxt = 1'b0;
      do_clear       = 1'b1;
      res_valid      = 1'b1;
      res.kind       = KIND_STOP;
    end else if (rx_byte == CH_CR || rx_byte == CH_SEMI) begin
      in_comment_nxt = 1'b1;
    end else if (rx_byte == CH_LF) begin
      do_finish = 1'b1;
    end else begin
      // Feed one character into the line
      if (rx_byte != CH_SPACE) nonempty_nxt = 1'b1;
      if (!line_error_r) begin
        case (phase_r)
          PH_LETTER: begin
            if (rx_byte == CH_G || rx_byte == CH_M) begin
              letter_nxt = (rx_byte == CH_M);
              phase_nxt  = PH_OPCODE;
            end else if (rx_byte != CH_SPACE) begin
              line_error_nxt = 1'b1;
            end
          end
          PH_OPCODE: begin
            if (is_digit) begin
              opcode_nxt = (op_wide[19:16] != 4'd0) ? OPCODE_MAX : op_wide[15:0];
            end else if (rx_byte == CH_SPACE) begin
              phase_nxt = PH_ARG_NAME;
            end else begin
              line_error_nxt = 1'b1;
            end
          end
          PH_ARG_NAME: begin
            if (rx_byte == CH_X || rx_byte == CH_Y || rx_byte == CH_Z ||
                rx_byte == CH_F) begin
              if (rx_byte == CH_X)      axis_nxt = AXIS_X;
              else if (rx_byte == CH_Y) axis_nxt = AXIS_Y;
              else if (rx_byte == CH_Z) axis_nxt = AXIS_Z;
              else                      axis_nxt = AXIS_F;
              phase_nxt              = PH_ARG_DIG;
              neg_nxt                = 1'b0;
              args_nxt[axis_nxt]     = '0;
              present_nxt[axis_nxt]  = 1'b1;
            end else if (rx_byte != CH_SPACE) begin
              line_error_nxt = 1'b1;
            end
          end
          PH_ARG_DIG: begin
            if (rx_byte == CH_MINUS) begin
              neg_nxt = 1'b1;
            end else if (is_digit) begin
              if (arg_wide[35:31] == 5'b00000 || arg_wide[35:31] == 5'b11111)
                args_nxt[axis_r] = arg_wide[31:0];
              else if (arg_wide[35])
                args_nxt[axis_r] = ARG_MIN;
              else
                args_nxt[axis_r] = ARG_MAX;
            end else if (rx_byte == CH_SPACE) begin
              phase_nxt = PH_ARG_NAME;
            end else begin
              line_error_nxt = 1'b1;
            end
          end
          default: begin
            line_error_nxt = 1'b1;
          end
        endcase
      end
    end

    // Report a finished line
    if (do_finish) begin
      do_clear = 1'b1;
      if (nonempty_r) begin
        res_valid = 1'b1;
        if (line_error_r) begin
          res.kind = KIND_ERROR;
        end else begin
          res.kind         = KIND_CMD;
          res.letter_is_m  = letter_r;
          res.opcode       = opcode_r;
          res.present_mask = present_r;
          res.x_value      = present_r[AXIS_X] ? args_r[AXIS_X] : '0;
          res.y_value      = present_r[AXIS_Y] ? args_r[AXIS_Y] : '0;
          res.z_value      = present_r[AXIS_Z] ? args_r[AXIS_Z] : '0;
          res.feed_value   = present_r[AXIS_F] ? args_r[AXIS_F] : '0;
        end
      end
    end

    // Drop all line state
    if (do_clear) begin
      phase_nxt      = PH_LETTER;
      line_error_nxt = 1'b0;
      nonempty_nxt   = 1'b0;
      letter_nxt     = 1'b0;
      opcode_nxt     = '0;
      axis_nxt       = AXIS_X;
      neg_nxt        = 1'b0;
      present_nxt    = '0;
      for (int i = 0; i < 4; i++) args_nxt[i] = '0;
    end
  end

  // Advance parser state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_program_r <= 1'b0;
      in_comment_r <= 1'b0;
      phase_r      <= PH_LETTER;
      line_error_r <= 1'b0;
      nonempty_r   <= 1'b0;
      letter_r     <= 1'b0;
      opcode_r     <= '0;
      axis_r       <= AXIS_X;
      neg_r        <= 1'b0;
      present_r    <= '0;
      for (int i = 0; i < 4; i++) args_r[i] <= '0;
    end else if (step) begin
      in_program_r <= in_program_nxt;
      in_comment_r <= in_comment_nxt;
      phase_r      <= phase_nxt;
      line_error_r <= line_error_nxt;
      nonempty_r   <= nonempty_nxt;
      letter_r     <= letter_nxt;
      opcode_r     <= opcode_nxt;
      axis_r       <= axis_nxt;
      neg_r        <= neg_nxt;
      present_r    <= present_nxt;
      for (int i = 0; i < 4; i++) args_r[i] <= args_nxt[i];
    end
  end

endmodule

`default_nettype wire

[src/gcode_command_line_parser.sv]
// G-code line parser top level: input byte register, parser core, result register.
// Depends on gclp_pkg, gclp_if and gclp_core.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one received character per cycle on in_ch when not stalled, and reports
// program start, program stop, a parsed G/M command or a line error on out_ch. A
// byte enters an input register, is parsed by the core once the result slot is
// free or being taken, and any result lands in the output register: out_ch.valid
// rises at the edge on which the core parses its byte. The sustained rate is one
// byte per cycle, set by the single parser state update per byte; while a result
// waits the input register takes one more byte, and the input stalls only when a
// result is held and the next byte is ready to be parsed.
module gcode_command_line_parser
  import gclp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  gclp_in_if.sink    in_ch,
  gclp_out_if.source out_ch
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_data_r;

  logic    advance;
  logic    core_valid;
  result_t core_res;

  // Parse the held byte once the result slot is free or being taken
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  gclp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (s1_byte_r),
    .res_valid (core_valid),
    .res       (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready) s1_valid_nxt = 1'b1;
    else if (advance)               s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = core_valid;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // Hold control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payload words
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_byte_r <= in_ch.rx_byte;
    if (advance && core_valid)      out_data_r <= core_res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_data_r.kind;
  assign out_ch.letter_is_m  = out_data_r.letter_is_m;
  assign out_ch.opcode       = out_data_r.opcode;
  assign out_ch.present_mask = out_data_r.present_mask;
  assign out_ch.x_value      = out_data_r.x_value;
  assign out_ch.y_value      = out_data_r.y_value;
  assign out_ch.z_value      = out_data_r.z_value;
  assign out_ch.feed_value   = out_data_r.feed_value;

endmodule

`default_nettype wire
